@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pn_pkg.sv @@
// ---------------------------------------------------------------------------
// pn_pkg
// shared types and constants of the path normalizer
// ---------------------------------------------------------------------------
package pn_pkg;

  // payload widths
  localparam int CHAR_W      = 8;
  localparam int DEPTH_W     = 5;
  localparam int CMD_W       = 2;
  localparam int OUT_TDATA_W = 16;

  // characters with a meaning in a path
  localparam logic [CHAR_W-1:0] SLASH_CHAR = 8'h2F;
  localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2E;

  // input item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR = 2'd0,
    CMD_END  = 2'd1,
    CMD_PULL = 2'd2
  } command_t;

  // result item kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_CHAR   = 1'b1;

  // path phase
  typedef enum logic [1:0] {
    PH_COLLECT = 2'd0,
    PH_READ    = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_PUT  = 1'b1
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take_char;
    logic end_path;
    logic pull;
    logic load_out;
  } pn_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic reading;
    logic out_free;
  } pn_sts_t;

endpackage

@@ design/pn_ram.sv @@
// ---------------------------------------------------------------------------
// pn_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/pn_ctrl.sv @@
// ---------------------------------------------------------------------------
// pn_ctrl
// input handshake and command sequencing of the path normalizer
// ---------------------------------------------------------------------------
module pn_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pn_pkg::CMD_W-1:0]        in_tuser,
  input  pn_pkg::pn_sts_t                 sts,
  output pn_pkg::pn_ctl_t                 ctl
);

  import pn_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  command_t   cmd;

  assign cmd = command_t'(in_tuser);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (cmd)
            CMD_CHAR: begin
              ctl.take_char = 1'b1;
            end
            CMD_END: begin
              ctl.end_path = 1'b1;
              state_nxt    = ST_PUT;
            end
            CMD_PULL: begin
              // a pull outside readout gives nothing
              if (sts.reading) begin
                ctl.pull  = 1'b1;
                state_nxt = ST_PUT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PUT: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ design/pn_dpath.sv @@
// ---------------------------------------------------------------------------
// pn_dpath
// name stack, name store, readout counters and output register
// ---------------------------------------------------------------------------
module pn_dpath #(
  parameter int MAX_LEVELS = 16,
  parameter int NAME_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pn_pkg::pn_ctl_t                  ctl,
  output pn_pkg::pn_sts_t                  sts,
  input  logic [pn_pkg::CHAR_W-1:0]        path_char,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pn_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  import pn_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int SW = $clog2(MAX_LEVELS + 1);
  localparam int OW = $clog2(NAME_BYTES);
  localparam int CW = $clog2(NAME_BYTES + 1);
  localparam int AW = $clog2(MAX_LEVELS * NAME_BYTES);
  localparam int DEPTH = MAX_LEVELS * NAME_BYTES;

  localparam logic [CW-1:0] KEEP_LEN = CW'(NAME_BYTES - 1);
  localparam logic [CW-1:0] FULL_LEN = CW'(NAME_BYTES);
  localparam logic [SW-1:0] MAX_TOP  = SW'(MAX_LEVELS);

  // control state
  phase_t         phase_r,   phase_nxt;
  logic [SW-1:0]  top_r,     top_nxt;
  logic [CW-1:0]  cur_len_r, cur_len_nxt;
  logic [15:0]    first2_r,  first2_nxt;
  logic           ovf_r,     ovf_nxt;
  logic [LW-1:0]  lvl_r,     lvl_nxt;
  logic [OW-1:0]  off_r,     off_nxt;
  logic           out_valid_r;

  // payload state
  logic [OW-1:0]  lens_r [MAX_LEVELS];
  logic           pend_kind_r, pend_kind_nxt;
  logic           pend_slash_r, pend_slash_nxt;
  logic           pend_last_r, pend_last_nxt;
  logic           out_kind_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic           out_last_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic           out_ovf_r;

  // name store ports
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic              st_re;
  logic [AW-1:0]     st_raddr;
  logic [CHAR_W-1:0] st_rdata;

  // name length write
  logic              len_we;
  logic [LW-1:0]     len_widx;
  logic [OW-1:0]     len_wval;

  pn_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (path_char),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // next state of stack, name in progress and readout
  always_comb begin
    logic [SW-1:0] top_e;
    logic [CW-1:0] len_e;
    logic [15:0]   first2_e;
    logic          ovf_e;
    logic          do_close;
    logic [OW-1:0] len_cur;
    logic          at_end;

    phase_nxt      = phase_r;
    top_nxt        = top_r;
    cur_len_nxt    = cur_len_r;
    first2_nxt     = first2_r;
    ovf_nxt        = ovf_r;
    lvl_nxt        = lvl_r;
    off_nxt        = off_r;
    pend_kind_nxt  = pend_kind_r;
    pend_slash_nxt = pend_slash_r;
    pend_last_nxt  = pend_last_r;
    st_we          = 1'b0;
    st_waddr       = AW'(top_r[LW-1:0]) * AW'(NAME_BYTES) + AW'(cur_len_r);
    st_re          = 1'b0;
    st_raddr       = AW'(lvl_r) * AW'(NAME_BYTES) + AW'(off_r) - AW'(1);
    len_we         = 1'b0;
    len_widx       = top_r[LW-1:0];
    len_wval       = cur_len_r[OW-1:0];
    len_cur        = lens_r[lvl_r];
    at_end         = 1'b0;

    // a character during or after readout starts a new path
    top_e    = top_r;
    len_e    = cur_len_r;
    first2_e = first2_r;
    ovf_e    = ovf_r;
    if (ctl.take_char && phase_r != PH_COLLECT) begin
      top_e    = '0;
      len_e    = '0;
      first2_e = '0;
      ovf_e    = 1'b0;
      lvl_nxt  = '0;
      off_nxt  = '0;
    end

    do_close = (ctl.take_char && path_char == SLASH_CHAR) ||
               (ctl.end_path && phase_r == PH_COLLECT);

    if (ctl.take_char) begin
      phase_nxt   = PH_COLLECT;
      top_nxt     = top_e;
      cur_len_nxt = len_e;
      first2_nxt  = first2_e;
      ovf_nxt     = ovf_e;
      if (path_char != SLASH_CHAR) begin
        // remember the first two characters to spot dot names
        if (len_e == CW'(0)) begin
          first2_nxt = {path_char, 8'h00};
        end else if (len_e == CW'(1)) begin
          first2_nxt = {first2_e[15:8], path_char};
        end
        st_waddr = AW'(top_e[LW-1:0]) * AW'(NAME_BYTES) + AW'(len_e);
        st_we    = (len_e < KEEP_LEN) && (top_e < MAX_TOP);
        if (len_e < FULL_LEN) begin
          cur_len_nxt = len_e + CW'(1);
        end
      end
    end

    // close the name in progress
    if (do_close) begin
      cur_len_nxt = '0;
      if (len_e != CW'(0)) begin
        first2_nxt = '0;
        if (len_e == CW'(1) && first2_e[15:8] == DOT_CHAR) begin
          // single dot: dropped
        end else if (len_e == CW'(2) && first2_e == {DOT_CHAR, DOT_CHAR}) begin
          // double dot: pop, never above the root
          if (top_e != '0) begin
            top_nxt = top_e - SW'(1);
          end
        end else if (top_e < MAX_TOP) begin
          len_we   = 1'b1;
          len_widx = top_e[LW-1:0];
          if (len_e > KEEP_LEN) begin
            len_wval = KEEP_LEN[OW-1:0];
            ovf_nxt  = 1'b1;
          end else begin
            len_wval = len_e[OW-1:0];
          end
          top_nxt = top_e + SW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end

    // end of path: status result, readout restarts
    if (ctl.end_path) begin
      phase_nxt      = PH_READ;
      lvl_nxt        = '0;
      off_nxt        = '0;
      pend_kind_nxt  = KIND_STATUS;
      pend_slash_nxt = 1'b0;
      pend_last_nxt  = 1'b0;
    end

    // pull: leading slash of a level, or a name character from the store
    if (ctl.pull) begin
      pend_kind_nxt = KIND_CHAR;
      if (off_r == '0) begin
        pend_slash_nxt = 1'b1;
        at_end         = (top_r == '0);
        off_nxt        = OW'(1);
      end else begin
        pend_slash_nxt = 1'b0;
        st_re          = 1'b1;
        at_end         = ((SW + 1)'(lvl_r) + (SW + 1)'(1) >= (SW + 1)'(top_r)) &&
                         (off_r >= len_cur);
        if (off_r >= len_cur) begin
          lvl_nxt = lvl_r + LW'(1);
          off_nxt = '0;
        end else begin
          off_nxt = off_r + OW'(1);
        end
      end
      pend_last_nxt = at_end;
      if (at_end) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_COLLECT;
      top_r     <= '0;
      cur_len_r <= '0;
      first2_r  <= '0;
      ovf_r     <= 1'b0;
      lvl_r     <= '0;
      off_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      top_r     <= top_nxt;
      cur_len_r <= cur_len_nxt;
      first2_r  <= first2_nxt;
      ovf_r     <= ovf_nxt;
      lvl_r     <= lvl_nxt;
      off_r     <= off_nxt;
    end
  end

  // name lengths and pending result
  always_ff @(posedge clk) begin
    if (len_we) begin
      lens_r[len_widx] <= len_wval;
    end
    pend_kind_r  <= pend_kind_nxt;
    pend_slash_r <= pend_slash_nxt;
    pend_last_r  <= pend_last_nxt;
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_kind_r  <= pend_kind_r;
      out_last_r  <= pend_last_r;
      out_depth_r <= DEPTH_W'(top_r);
      out_ovf_r   <= ovf_r;
      if (pend_kind_r == KIND_STATUS) begin
        out_char_r <= '0;
      end else if (pend_slash_r) begin
        out_char_r <= SLASH_CHAR;
      end else begin
        out_char_r <= st_rdata;
      end
    end
  end

  assign sts.reading  = (phase_r == PH_READ);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_ovf_r, out_depth_r, out_char_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

@@ design/path_normalizer.sv @@
// ---------------------------------------------------------------------------
// path_normalizer
// streaming unix path normalizer with a stack of names
// ---------------------------------------------------------------------------
// A path character item is taken while the controller is idle; an end item
// and a pull item each move it to the state that loads the output register
// (a pull starts the name store's registered read). An end or pull item
// waits further while the previous result has not been taken. Path characters
// give no result; an end item gives a status item with depth and overflow;
// each pull during readout gives one character of the clean path, the final
// one with tlast. The name store needs no clearing after reset.
module path_normalizer #(
  parameter int MAX_LEVELS = 16,
  parameter int NAME_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // path_char
  input  logic [pn_pkg::CMD_W-1:0]       in_tuser,   // command
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [pn_pkg::OUT_TDATA_W-1:0] out_tdata,  // out_char, depth, overflow
  output logic                           out_tuser,  // kind
  output logic                           out_tlast   // out_last
);

  import pn_pkg::*;

  pn_ctl_t ctl;
  pn_sts_t sts;

  pn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .ctl       (ctl)
  );

  pn_dpath #(
    .MAX_LEVELS (MAX_LEVELS),
    .NAME_BYTES (NAME_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .path_char  (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`include "assert_macros.svh"

  // an accepted end item blocks input while its status is placed
  `PN_ASSERT_NEXT(a_end_blocks, in_tvalid && in_tready && in_tuser == CMD_END, !in_tready, "end item did not hold off input")

  // a loaded result is presented in the next cycle
  `PN_ASSERT_NEXT(a_load_shows, ctl.load_out, out_tvalid, "loaded result not presented")

  // status items carry no character and no last mark
  `PN_ASSERT_NOW(a_status_clean, out_tvalid && out_tuser == KIND_STATUS, out_tdata[7:0] == 8'h00 && !out_tlast, "status item carries character data")

endmodule

@@ verif/tb_path_normalizer.sv @@
// ---------------------------------------------------------------------------
// tb_path_normalizer
// self-checking bench: directed paths from a table, then random paths under
// changing stall patterns, every result item checked against a path predictor
// ---------------------------------------------------------------------------
module tb_path_normalizer;
  import pn_pkg::*;

  localparam int MAX_LEVELS   = 16;
  localparam int NAME_BYTES   = 32;
  localparam int DEPTH_LSB    = CHAR_W;
  localparam int OVF_BIT      = CHAR_W + DEPTH_W;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_ITEMS  = 380;

  // the one command code the package leaves out
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // one result item, split into its fields
  typedef struct packed {
    logic               kind;
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [DEPTH_W-1:0] depth;
    logic               ovf;
  } path_result_t;

  // one row of the directed table; text, when set, replaces ch
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    string             text;
    int                reps;
    bit                typed;
    path_result_t      want;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;  // path_char
  logic [CMD_W-1:0]       in_tuser   = '0;  // command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // out_char, depth, overflow
  logic                   out_tuser;        // kind
  logic                   out_tlast;        // out_last

  // predictor state
  logic [CHAR_W-1:0] name_chars [MAX_LEVELS*NAME_BYTES];
  logic [4:0]        name_len   [MAX_LEVELS];
  int unsigned       level_count;
  int unsigned       char_count;
  int unsigned       read_level;
  int unsigned       read_offset;
  logic [15:0]       head_pair;
  phase_t            path_phase;
  bit                trunc_flag;

  path_result_t clean_path_q [$];
  int unsigned  path_item_count  = 0;
  int unsigned  bad_result_count = 0;
  int unsigned  send_gap_pct     = 0;
  int unsigned  recv_stall_pct   = 0;

  path_normalizer #(
    .MAX_LEVELS(MAX_LEVELS),
    .NAME_BYTES(NAME_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // clear stack, name in progress, flag and readout position
  function automatic void restart_path();
    level_count = 0;
    char_count  = 0;
    head_pair   = '0;
    trunc_flag  = 1'b0;
    read_level  = 0;
    read_offset = 0;
    path_phase  = PH_COLLECT;
  endfunction

  // finish the name in progress: drop, pop or push
  function automatic void close_name();
    int unsigned len;
    len = char_count;
    char_count = 0;
    if (len == 0) return;
    if (len == 1 && head_pair[15:8] == DOT_CHAR) begin
      // single dot stays at the same level
    end else if (len == 2 && head_pair == {DOT_CHAR, DOT_CHAR}) begin
      if (level_count > 0) level_count--;
    end else if (level_count < MAX_LEVELS) begin
      if (len > NAME_BYTES - 1) begin
        len = NAME_BYTES - 1;
        trunc_flag = 1'b1;
      end
      name_len[level_count] = 5'(len);
      level_count++;
    end else begin
      trunc_flag = 1'b1;
    end
    head_pair = '0;
  endfunction

  // advance the path predictor by one accepted item; returns 1 if the item
  // did anything, with the result item it causes in res when produced is set
  function automatic bit normalize_item(input logic [CMD_W-1:0] cmd,
                                        input logic [CHAR_W-1:0] ch,
                                        output bit produced, output path_result_t res);
    int unsigned       lvl;
    int unsigned       len;
    int unsigned       off;
    logic [CHAR_W-1:0] c;
    bit                last;
    produced = 1'b0;
    res      = '0;
    case (cmd)
      CMD_CHAR: begin
        if (path_phase != PH_COLLECT) restart_path();
        if (ch == SLASH_CHAR) begin
          close_name();
        end else begin
          if (char_count == 0) head_pair = {ch, 8'h00};
          else if (char_count == 1) head_pair[7:0] = ch;
          if (char_count < NAME_BYTES - 1 && level_count < MAX_LEVELS)
            name_chars[level_count*NAME_BYTES + char_count] = ch;
          if (char_count < NAME_BYTES) char_count++;
        end
        return 1'b1;
      end
      CMD_END: begin
        if (path_phase == PH_COLLECT) close_name();
        path_phase  = PH_READ;
        read_level  = 0;
        read_offset = 0;
        produced    = 1'b1;
        res = '{kind: KIND_STATUS, ch: '0, last: 1'b0,
                depth: DEPTH_W'(level_count), ovf: trunc_flag};
        return 1'b1;
      end
      default: begin
        if (cmd != CMD_PULL || path_phase != PH_READ) return 1'b0;
        // leading slash, then each kept name with a slash between
        if (read_offset == 0) begin
          c = SLASH_CHAR;
          last = (level_count == 0);
          read_offset = 1;
        end else begin
          lvl = (read_level < MAX_LEVELS) ? read_level : MAX_LEVELS - 1;
          len = name_len[lvl];
          off = read_offset - 1;
          if (off > NAME_BYTES - 1) off = NAME_BYTES - 1;
          c = name_chars[lvl*NAME_BYTES + off];
          last = (read_level + 1 >= level_count) && (read_offset >= len);
          if (read_offset >= len) begin
            read_level++;
            read_offset = 0;
          end else begin
            read_offset++;
          end
        end
        if (last) path_phase = PH_DONE;
        produced = 1'b1;
        res = '{kind: KIND_CHAR, ch: c, last: last,
                depth: DEPTH_W'(level_count), ovf: trunc_flag};
        return 1'b1;
      end
    endcase
  endfunction

  // send one item, with random idle cycles first; called at a falling edge
  task automatic feed(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                      input bit typed = 1'b0, input path_result_t want = '0);
    bit           produced;
    path_result_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 2'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    if (normalize_item(cmd, ch, produced, res)) path_item_count++;
    if (produced) clean_path_q.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // one random path: names, then an end and a full, partial or restarted readout, or no end
  task automatic random_path();
    int unsigned      names;
    int unsigned      pick;
    int unsigned      len;
    logic [CMD_W-1:0] stray;
    // stray items ahead of the path
    if ($urandom_range(99) < 8) begin
      stray = $urandom_range(1) ? CMD_UNUSED : CMD_PULL;
      feed(stray, 8'($urandom));
    end
    names = ($urandom_range(99) < 6) ? $urandom_range(14, 20) : $urandom_range(0, 5);
    if (names == 0 && $urandom_range(1)) feed(CMD_CHAR, SLASH_CHAR);
    for (int i = 0; i < names; i++) begin
      if (i > 0 || $urandom_range(99) < 80)
        repeat ($urandom_range(1, 3)) feed(CMD_CHAR, SLASH_CHAR);
      pick = $urandom_range(99);
      if (pick < 12) begin
        feed(CMD_CHAR, DOT_CHAR);
      end else if (pick < 30) begin
        repeat (2) feed(CMD_CHAR, DOT_CHAR);
      end else if (pick < 36) begin
        // dots followed by more: a name that is kept
        repeat ($urandom_range(1, 2)) feed(CMD_CHAR, DOT_CHAR);
        feed(CMD_CHAR, 8'($urandom));
      end else begin
        len = ($urandom_range(99) < 4) ? $urandom_range(NAME_BYTES - 3, NAME_BYTES + 8)
                                       : $urandom_range(1, 6);
        repeat (len) feed(CMD_CHAR, 8'($urandom));
      end
    end
    if ($urandom_range(99) < 30) feed(CMD_CHAR, SLASH_CHAR);
    // broken path: no end, the next path runs on into this one
    if ($urandom_range(99) < 4) return;
    feed(CMD_END, 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 25) begin
      repeat ($urandom_range(0, 3)) feed(CMD_PULL, 8'($urandom));
      // abandon the readout; the next path character starts over
      if (pick < 15) return;
      feed(CMD_END, 8'($urandom));
    end
    while (path_phase == PH_READ) feed(CMD_PULL, 8'($urandom));
    repeat ($urandom_range(0, 2)) feed(CMD_PULL, 8'($urandom));
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result item with the oldest predicted one
  always @(posedge clk) begin
    path_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (clean_path_q.size() == 0) begin
        bad_result_count++;
        if (bad_result_count <= REPORT_LIMIT)
          $display("%0t: result item with none expected: tdata %h tuser %b tlast %b",
                   $realtime, out_tdata, out_tuser, out_tlast);
      end else begin
        want = clean_path_q.pop_front();
        if (out_tuser !== want.kind || out_tdata[CHAR_W-1:0] !== want.ch ||
            out_tlast !== want.last || out_tdata[DEPTH_LSB +: DEPTH_W] !== want.depth ||
            out_tdata[OVF_BIT] !== want.ovf) begin
          bad_result_count++;
          if (bad_result_count <= REPORT_LIMIT) begin
            $write("%0t: mismatch (expected/actual) kind %b/%b char %h/%h", $realtime,
                   want.kind, out_tuser, want.ch, out_tdata[CHAR_W-1:0]);
            $display(" last %b/%b depth %0d/%0d overflow %b/%b",
                     want.last, out_tlast, want.depth, out_tdata[DEPTH_LSB +: DEPTH_W],
                     want.ovf, out_tdata[OVF_BIT]);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    plan_row_t   plan [$];
    int unsigned gap_pcts   [3] = '{8, 81, 0};
    int unsigned stall_pcts [3] = '{81, 8, 0};
    int unsigned target;

    restart_path();
    send_gap_pct   = gap_pcts[0];
    recv_stall_pct = stall_pcts[0];

    // pull before any path and the reserved command: nothing comes back
    plan.push_back('{CMD_PULL, 8'h00, "", 1, 1'b0, '0});
    plan.push_back('{CMD_UNUSED, 8'hFF, "", 1, 1'b0, '0});
    // empty path right after reset, then the root alone
    plan.push_back('{CMD_END, 8'h00, "", 1, 1'b1, '{KIND_STATUS, 8'h00, 1'b0, 5'd0, 1'b0}});
    plan.push_back('{CMD_PULL, 8'hFF, "", 1, 1'b1, '{KIND_CHAR, SLASH_CHAR, 1'b1, 5'd0, 1'b0}});
    // pull after the final character is ignored
    plan.push_back('{CMD_PULL, 8'h00, "", 1, 1'b0, '0});
    // zero and all-ones bytes are plain name characters
    plan.push_back('{CMD_CHAR, 8'h00, "", 1, 1'b0, '0});
    plan.push_back('{CMD_CHAR, 8'hFF, "", 1, 1'b0, '0});
    // dot dropped, dot-dot pops, dot-dot at the root stays there
    plan.push_back('{CMD_CHAR, 8'h00, "//./../../", 1, 1'b0, '0});
    // two dots heading a longer name: kept
    plan.push_back('{CMD_CHAR, 8'h00, "..y/", 1, 1'b0, '0});
    plan.push_back('{CMD_END, 8'h00, "", 1, 1'b0, '0});
    plan.push_back('{CMD_PULL, 8'h00, "", 2, 1'b0, '0});
    // end again mid-readout restarts it from the slash
    plan.push_back('{CMD_END, 8'hFF, "", 1, 1'b0, '0});
    plan.push_back('{CMD_PULL, 8'h00, "", 6, 1'b0, '0});
    // name too long for a slot, then more names than levels
    plan.push_back('{CMD_CHAR, 8'h00, "c", 40, 1'b0, '0});
    plan.push_back('{CMD_CHAR, 8'h00, "/b", 17, 1'b0, '0});
    plan.push_back('{CMD_END, 8'h00, "", 1, 1'b1, '{KIND_STATUS, 8'h00, 1'b0, 5'd16, 1'b1}});
    plan.push_back('{CMD_PULL, 8'h00, "", 64, 1'b0, '0});
    // path character while reading starts a fresh path
    plan.push_back('{CMD_END, 8'h00, "", 1, 1'b0, '0});
    plan.push_back('{CMD_PULL, 8'h00, "", 2, 1'b0, '0});
    plan.push_back('{CMD_CHAR, SLASH_CHAR, "", 1, 1'b0, '0});
    plan.push_back('{CMD_END, 8'h00, "", 1, 1'b1, '{KIND_STATUS, 8'h00, 1'b0, 5'd0, 1'b0}});
    plan.push_back('{CMD_PULL, 8'h00, "", 2, 1'b0, '0});

    // reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        if (plan[r].text.len() == 0)
          feed(plan[r].cmd, plan[r].ch, plan[r].typed, plan[r].want);
        else
          for (int j = 0; j < plan[r].text.len(); j++) feed(plan[r].cmd, plan[r].text[j]);
      end
    end

    // random paths under three idle patterns
    for (int p = 0; p < 3; p++) begin
      send_gap_pct   = gap_pcts[p];
      recv_stall_pct = stall_pcts[p];
      target = path_item_count + PHASE_ITEMS;
      while (path_item_count < target) random_path();
    end
    in_tvalid <= 1'b0;

    // drain outstanding results, then wait quietly before the verdict
    while (clean_path_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_result_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
